[rtl/core/bsp_pkg.sv]
package bsp_pkg;

    localparam int TILE_SIZE   = 64;
    localparam int ANGLE_STEPS = 4096;
    localparam int HALF_TILE   = TILE_SIZE * 128;
    localparam int PHASE_SPAN  = 65536;

    localparam int SIN_A = 25736;
    localparam int SIN_B = 10512;
    localparam int SIN_C = 1160;

    localparam int SIZE_SHIFT = 22;
    localparam int DEP_SHIFT  = 14;

    localparam int ANGLE_W  = 12;
    localparam int POS_W    = 16;
    localparam int VIEW_W   = 23;
    localparam int WIN_W    = 11;
    localparam int DEP_W    = 24;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd1;

    localparam int DX_W     = 26;
    localparam int P_W      = 42;
    localparam int D_W      = 43;
    localparam int NUMC_W   = 50;
    localparam int DEN_W    = 50;
    localparam int WN_W     = 62;
    localparam int QC_W     = 35;
    localparam int QS_W     = 35;
    localparam int REMC_W   = DEN_W + 1;
    localparam int REMS_W   = D_W + 1;
    localparam int CEN_W    = QC_W + 2;
    localparam int SPAN_W   = QC_W + 3;

    localparam int DIV_STEPS = QC_W;
    localparam int ST_DIV0   = 12;
    localparam int ST_POST1  = ST_DIV0 + DIV_STEPS;
    localparam int ST_OUT    = ST_POST1 + 1;
    localparam int N_ST      = ST_OUT + 1;

    typedef struct packed {
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic [VIEW_W-1:0]        vx;
        logic [VIEW_W-1:0]        vy;
        logic [ANGLE_W-1:0]       ang;
        logic [14:0]              sa;
        logic [14:0]              ca;
        logic                     sn;
        logic                     cn;
        logic [14:0]              sz;
        logic [14:0]              cz;
        logic [13:0]              stb;
        logic [13:0]              ctb;
        logic [14:0]              st2;
        logic [14:0]              ct2;
        logic signed [15:0]       s;
        logic signed [15:0]       c;
        logic signed [DX_W-1:0]   dx;
        logic signed [DX_W-1:0]   dy;
        logic signed [P_W-1:0]    pcx;
        logic signed [P_W-1:0]    psy;
        logic signed [P_W-1:0]    pcy;
        logic signed [P_W-1:0]    psx;
        logic signed [D_W-1:0]    d;
        logic signed [D_W-1:0]    lat;
        logic                     vis;
        logic signed [NUMC_W-1:0] numc;
        logic [DEN_W-1:0]         den;
        logic [D_W-1:0]           sden;
        logic [DEP_W-1:0]         dep;
        logic signed [WN_W-1:0]   wnum;
        logic [WN_W-1:0]          mag;
        logic                     nneg;
        logic [REMC_W-1:0]        rc;
        logic [REMS_W-1:0]        rs;
        logic [QC_W-1:0]          qc;
        logic [QC_W-1:0]          ncl;
        logic [QS_W-1:0]          qs;
        logic [QS_W-1:0]          nsz;
        logic                     cov;
        logic signed [CEN_W-1:0]  cen;
        logic signed [SPAN_W-1:0] cs;
        logic signed [SPAN_W-1:0] ce;
        logic signed [SPAN_W-1:0] rws;
        logic signed [SPAN_W-1:0] rwe;
        logic [15:0]              ocen;
        logic [15:0]              osize;
        logic [WIN_W-1:0]         ocs;
        logic [WIN_W-1:0]         oce;
        logic [WIN_W-1:0]         ors;
        logic [WIN_W-1:0]         ore;
    } t_item;

    function automatic logic [WIN_W-1:0] f_clamp(
        input logic signed [SPAN_W-1:0] v,
        input logic [WIN_W-1:0]         lim
    );
        logic [WIN_W-1:0] res;
        if (v[SPAN_W-1]) begin
            res = '0;
        end else if (v > SPAN_W'(lim)) begin
            res = lim;
        end else begin
            res = v[WIN_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/bsp_if.sv]
interface bsp_in_if;
    logic                            valid;
    logic                            ready;
    logic [bsp_pkg::POS_W-1:0]       sprite_col;
    logic [bsp_pkg::POS_W-1:0]       sprite_row;
    logic [bsp_pkg::VIEW_W-1:0]      viewer_x;
    logic [bsp_pkg::VIEW_W-1:0]      viewer_y;
    logic [bsp_pkg::ANGLE_W-1:0]     viewer_angle;

    modport source (output valid, sprite_col, sprite_row, viewer_x, viewer_y, viewer_angle,
                    input ready);
    modport sink   (input valid, sprite_col, sprite_row, viewer_x, viewer_y, viewer_angle,
                    output ready);
endinterface

interface bsp_out_if;
    logic                            valid;
    logic                            ready;
    logic                            visible;
    logic signed [15:0]              center_column;
    logic [15:0]                     sprite_size;
    logic [bsp_pkg::WIN_W-1:0]       start_column;
    logic [bsp_pkg::WIN_W-1:0]       end_column;
    logic [bsp_pkg::WIN_W-1:0]       start_row;
    logic [bsp_pkg::WIN_W-1:0]       end_row;
    logic [bsp_pkg::DEP_W-1:0]       depth;

    modport source (output valid, visible, center_column, sprite_size, start_column,
                    end_column, start_row, end_row, depth, input ready);
    modport sink   (input valid, visible, center_column, sprite_size, start_column,
                    end_column, start_row, end_row, depth, output ready);
endinterface

interface bsp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bsp_pkg::IDX_W-1:0]       index;
    logic [bsp_pkg::WIN_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/billboard_sprite_projection_unit.sv]
// One request per cycle while the output is not stalled; the two dividers are 35-step restoring
// pipelines, one quotient bit per stage, and every stage holds its own item.
// Stalled stages hold; empty stages still fill, so input is taken while a result waits if any stage is empty.
// Reset clears all stage valid bits and sets the window to 640 x 480.
module billboard_sprite_projection_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsp_in_if.sink        i_in,
    bsp_out_if.source     o_out,
    bsp_cfg_if.sink       i_cfg
);

    logic [bsp_pkg::WIN_W-1:0] r_w;
    logic [bsp_pkg::WIN_W-1:0] r_h;
    logic [bsp_pkg::WIN_W-1:0] wlim;
    logic [bsp_pkg::WIN_W-1:0] hlim;

    logic [bsp_pkg::N_ST-1:0]  r_v;
    logic [bsp_pkg::N_ST-1:0]  adv;
    bsp_pkg::t_item            r_p [bsp_pkg::N_ST];
    bsp_pkg::t_item            n_p [bsp_pkg::N_ST];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= bsp_pkg::WIN_W'(640);
            r_h <= bsp_pkg::WIN_W'(480);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == bsp_pkg::REG_WINDOW_WIDTH) begin
                r_w <= i_cfg.data;
            end else if (i_cfg.index == bsp_pkg::REG_WINDOW_HEIGHT) begin
                r_h <= i_cfg.data;
            end
        end
    end

    assign wlim = (r_w != '0) ? r_w - 1'b1 : '0;
    assign hlim = (r_h != '0) ? r_h - 1'b1 : '0;

    always_comb begin
        adv[bsp_pkg::N_ST-1] = !r_v[bsp_pkg::N_ST-1] || o_out.ready;
        for (int k = bsp_pkg::N_ST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign i_in.ready = adv[0];

    always_comb begin
        logic [15:0]                 ph;
        logic [15:0]                 phc;
        logic [29:0]                 m;
        logic [bsp_pkg::REMC_W-1:0]  remc;
        logic [bsp_pkg::REMS_W-1:0]  rems;
        logic [bsp_pkg::QC_W-1:0]    cq;
        logic [bsp_pkg::QS_W-2:0]    half;
        logic [bsp_pkg::WIN_W-2:0]   hh;

        n_p[0]        = '0;
        n_p[0].col    = i_in.sprite_col;
        n_p[0].row    = i_in.sprite_row;
        n_p[0].vx     = i_in.viewer_x;
        n_p[0].vy     = i_in.viewer_y;
        n_p[0].ang    = i_in.viewer_angle;
        for (int k = 1; k < bsp_pkg::N_ST; k++) begin
            n_p[k] = r_p[k-1];
        end

        // phase, quarter-wave arguments, world offsets
        ph  = 16'(((32'(r_p[0].ang) % bsp_pkg::ANGLE_STEPS) * bsp_pkg::PHASE_SPAN)
                  / bsp_pkg::ANGLE_STEPS);
        phc = ph + 16'h4000;
        n_p[1].sa = ph[14]  ? 15'h4000 - {1'b0, ph[13:0]}  : {1'b0, ph[13:0]};
        n_p[1].ca = phc[14] ? 15'h4000 - {1'b0, phc[13:0]} : {1'b0, phc[13:0]};
        n_p[1].sn = ph[15];
        n_p[1].cn = phc[15];
        n_p[1].dx = bsp_pkg::DX_W'(r_p[0].col) * bsp_pkg::DX_W'(bsp_pkg::TILE_SIZE)
                  + bsp_pkg::DX_W'(bsp_pkg::HALF_TILE) - bsp_pkg::DX_W'(r_p[0].vx);
        n_p[1].dy = bsp_pkg::DX_W'(r_p[0].row) * bsp_pkg::DX_W'(bsp_pkg::TILE_SIZE)
                  + bsp_pkg::DX_W'(bsp_pkg::HALF_TILE) - bsp_pkg::DX_W'(r_p[0].vy);

        m = (30'(r_p[1].sa) * 30'(r_p[1].sa)) >> 14;
        n_p[2].sz = m[14:0];
        m = (30'(r_p[1].ca) * 30'(r_p[1].ca)) >> 14;
        n_p[2].cz = m[14:0];

        m = 30'(bsp_pkg::SIN_B) - ((30'(bsp_pkg::SIN_C) * 30'(r_p[2].sz)) >> 14);
        n_p[3].stb = m[13:0];
        m = 30'(bsp_pkg::SIN_B) - ((30'(bsp_pkg::SIN_C) * 30'(r_p[2].cz)) >> 14);
        n_p[3].ctb = m[13:0];

        m = 30'(bsp_pkg::SIN_A) - ((30'(r_p[3].stb) * 30'(r_p[3].sz)) >> 14);
        n_p[4].st2 = m[14:0];
        m = 30'(bsp_pkg::SIN_A) - ((30'(r_p[3].ctb) * 30'(r_p[3].cz)) >> 14);
        n_p[4].ct2 = m[14:0];

        m = (30'(r_p[4].st2) * 30'(r_p[4].sa)) >> 14;
        n_p[5].s = r_p[4].sn ? -16'(m[14:0]) : 16'(m[14:0]);
        m = (30'(r_p[4].ct2) * 30'(r_p[4].ca)) >> 14;
        n_p[5].c = r_p[4].cn ? -16'(m[14:0]) : 16'(m[14:0]);

        // rotate into camera space
        n_p[6].pcx = bsp_pkg::P_W'(r_p[5].c) * bsp_pkg::P_W'(r_p[5].dx);
        n_p[6].psy = bsp_pkg::P_W'(r_p[5].s) * bsp_pkg::P_W'(r_p[5].dy);
        n_p[6].pcy = bsp_pkg::P_W'(r_p[5].c) * bsp_pkg::P_W'(r_p[5].dy);
        n_p[6].psx = bsp_pkg::P_W'(r_p[5].s) * bsp_pkg::P_W'(r_p[5].dx);

        n_p[7].d   = bsp_pkg::D_W'(r_p[6].pcx) + bsp_pkg::D_W'(r_p[6].psy);
        n_p[7].lat = bsp_pkg::D_W'(r_p[6].pcy) - bsp_pkg::D_W'(r_p[6].psx);

        n_p[8].vis  = !r_p[7].d[bsp_pkg::D_W-1] && (r_p[7].d != '0);
        n_p[8].numc = bsp_pkg::NUMC_W'(r_p[7].d) * bsp_pkg::NUMC_W'(33)
                    + bsp_pkg::NUMC_W'(r_p[7].lat) * bsp_pkg::NUMC_W'(50);
        n_p[8].den  = bsp_pkg::DEN_W'(r_p[7].d) * bsp_pkg::DEN_W'(66);
        n_p[8].sden = r_p[7].d;
        n_p[8].dep  = (|r_p[7].d[bsp_pkg::D_W-1:bsp_pkg::DEP_SHIFT+bsp_pkg::DEP_W])
                    ? '1 : r_p[7].d[bsp_pkg::DEP_SHIFT+bsp_pkg::DEP_W-1:bsp_pkg::DEP_SHIFT];

        n_p[9].wnum = bsp_pkg::WN_W'(r_p[8].numc) * bsp_pkg::WN_W'(r_w);

        n_p[10].nneg = r_p[9].wnum[bsp_pkg::WN_W-1];
        n_p[10].mag  = r_p[9].wnum[bsp_pkg::WN_W-1] ? bsp_pkg::WN_W'(-r_p[9].wnum)
                                                    : bsp_pkg::WN_W'(r_p[9].wnum);

        // divider setup; quotients beyond QC_W bits saturate
        n_p[11].rc  = bsp_pkg::REMC_W'(r_p[10].mag[bsp_pkg::WN_W-1:bsp_pkg::QC_W]);
        n_p[11].cov = bsp_pkg::REMC_W'(r_p[10].mag[bsp_pkg::WN_W-1:bsp_pkg::QC_W])
                   >= bsp_pkg::REMC_W'(r_p[10].den);
        n_p[11].ncl = r_p[10].mag[bsp_pkg::QC_W-1:0];
        n_p[11].qc  = '0;
        n_p[11].rs  = '0;
        n_p[11].qs  = '0;
        n_p[11].nsz = bsp_pkg::QS_W'({r_h, bsp_pkg::SIZE_SHIFT'(0)});

        for (int k = bsp_pkg::ST_DIV0; k < bsp_pkg::ST_POST1; k++) begin
            remc = {r_p[k-1].rc[bsp_pkg::REMC_W-2:0], r_p[k-1].ncl[bsp_pkg::QC_W-1]};
            if (remc >= bsp_pkg::REMC_W'(r_p[k-1].den)) begin
                n_p[k].rc = remc - bsp_pkg::REMC_W'(r_p[k-1].den);
                n_p[k].qc = {r_p[k-1].qc[bsp_pkg::QC_W-2:0], 1'b1};
            end else begin
                n_p[k].rc = remc;
                n_p[k].qc = {r_p[k-1].qc[bsp_pkg::QC_W-2:0], 1'b0};
            end
            n_p[k].ncl = {r_p[k-1].ncl[bsp_pkg::QC_W-2:0], 1'b0};

            rems = {r_p[k-1].rs[bsp_pkg::REMS_W-2:0], r_p[k-1].nsz[bsp_pkg::QS_W-1]};
            if (rems >= bsp_pkg::REMS_W'(r_p[k-1].sden)) begin
                n_p[k].rs = rems - bsp_pkg::REMS_W'(r_p[k-1].sden);
                n_p[k].qs = {r_p[k-1].qs[bsp_pkg::QS_W-2:0], 1'b1};
            end else begin
                n_p[k].rs = rems;
                n_p[k].qs = {r_p[k-1].qs[bsp_pkg::QS_W-2:0], 1'b0};
            end
            n_p[k].nsz = {r_p[k-1].nsz[bsp_pkg::QS_W-2:0], 1'b0};
        end

        cq   = r_p[bsp_pkg::ST_POST1-1].cov ? '1 : r_p[bsp_pkg::ST_POST1-1].qc;
        half = r_p[bsp_pkg::ST_POST1-1].qs[bsp_pkg::QS_W-1:1];
        hh   = r_h[bsp_pkg::WIN_W-1:1];
        n_p[bsp_pkg::ST_POST1].cen = r_p[bsp_pkg::ST_POST1-1].nneg
                                   ? -bsp_pkg::CEN_W'(cq) : bsp_pkg::CEN_W'(cq);
        n_p[bsp_pkg::ST_POST1].cs  = bsp_pkg::SPAN_W'(n_p[bsp_pkg::ST_POST1].cen)
                                   - bsp_pkg::SPAN_W'(half);
        n_p[bsp_pkg::ST_POST1].ce  = bsp_pkg::SPAN_W'(n_p[bsp_pkg::ST_POST1].cen)
                                   + bsp_pkg::SPAN_W'(half);
        n_p[bsp_pkg::ST_POST1].rws = bsp_pkg::SPAN_W'(hh) - bsp_pkg::SPAN_W'(half);
        n_p[bsp_pkg::ST_POST1].rwe = bsp_pkg::SPAN_W'(hh) + bsp_pkg::SPAN_W'(half);

        // saturate, clamp, zero the fields of sprites not in front of the camera
        if (!r_p[bsp_pkg::ST_POST1].vis) begin
            n_p[bsp_pkg::ST_OUT].ocen  = '0;
            n_p[bsp_pkg::ST_OUT].osize = '0;
            n_p[bsp_pkg::ST_OUT].ocs   = '0;
            n_p[bsp_pkg::ST_OUT].oce   = '0;
            n_p[bsp_pkg::ST_OUT].ors   = '0;
            n_p[bsp_pkg::ST_OUT].ore   = '0;
            n_p[bsp_pkg::ST_OUT].dep   = '0;
        end else begin
            if (r_p[bsp_pkg::ST_POST1].cen > bsp_pkg::CEN_W'(32767)) begin
                n_p[bsp_pkg::ST_OUT].ocen = 16'h7fff;
            end else if (r_p[bsp_pkg::ST_POST1].cen < bsp_pkg::CEN_W'(-32768)) begin
                n_p[bsp_pkg::ST_OUT].ocen = 16'h8000;
            end else begin
                n_p[bsp_pkg::ST_OUT].ocen = r_p[bsp_pkg::ST_POST1].cen[15:0];
            end
            n_p[bsp_pkg::ST_OUT].osize = (|r_p[bsp_pkg::ST_POST1].qs[bsp_pkg::QS_W-1:16])
                                       ? 16'hffff : r_p[bsp_pkg::ST_POST1].qs[15:0];
            n_p[bsp_pkg::ST_OUT].ocs = bsp_pkg::f_clamp(r_p[bsp_pkg::ST_POST1].cs, wlim);
            n_p[bsp_pkg::ST_OUT].oce = bsp_pkg::f_clamp(r_p[bsp_pkg::ST_POST1].ce, wlim);
            n_p[bsp_pkg::ST_OUT].ors = bsp_pkg::f_clamp(r_p[bsp_pkg::ST_POST1].rws, hlim);
            n_p[bsp_pkg::ST_OUT].ore = bsp_pkg::f_clamp(r_p[bsp_pkg::ST_POST1].rwe, hlim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < bsp_pkg::N_ST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bsp_pkg::N_ST; k++) begin
            if (adv[k]) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    assign o_out.valid         = r_v[bsp_pkg::ST_OUT];
    assign o_out.visible       = r_p[bsp_pkg::ST_OUT].vis;
    assign o_out.center_column = r_p[bsp_pkg::ST_OUT].ocen;
    assign o_out.sprite_size   = r_p[bsp_pkg::ST_OUT].osize;
    assign o_out.start_column  = r_p[bsp_pkg::ST_OUT].ocs;
    assign o_out.end_column    = r_p[bsp_pkg::ST_OUT].oce;
    assign o_out.start_row     = r_p[bsp_pkg::ST_OUT].ors;
    assign o_out.end_row       = r_p[bsp_pkg::ST_OUT].ore;
    assign o_out.depth         = r_p[bsp_pkg::ST_OUT].dep;

    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.visible |->
            o_out.sprite_size == '0 && o_out.depth == '0 && o_out.end_column == '0
            && o_out.end_row == '0)
        else $error("hidden sprite carries nonzero fields");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.start_column <= wlim && o_out.end_column <= wlim
            && o_out.start_row <= hlim && o_out.end_row <= hlim)
        else $error("bounds outside window");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_v[bsp_pkg::N_ST-1] && !o_out.ready)
        else $error("input blocked without output stall");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v[0])
        else $error("accepted request lost at entry stage");

endmodule
